### design/rpsf_pkg.sv
`timescale 1ns / 1ps
package rpsf_pkg;

  typedef enum logic [2:0] {
    SYNC_FALL  = 3'd0,
    SYNC_RISE  = 3'd1,
    SYNC_EQUAL = 3'd2,
    SYNC_HOLD  = 3'd3,
    SYNC_HIGH  = 3'd4
  } sync_state_t;

  typedef enum logic [2:0] {
    MODE_NONE    = 3'd0,
    MODE_LOW     = 3'd1,
    MODE_FALL    = 3'd2,
    MODE_HIGH    = 3'd3,
    MODE_EQUAL   = 3'd4
  } wave_mode_t;

  localparam logic [7:0] WAVE_BYTE_04 = 8'h04;
  localparam logic [7:0] WAVE_BYTE_08 = 8'h08;
  localparam logic [7:0] WAVE_BYTE_10 = 8'h10;
  localparam logic [7:0] WAVE_BYTE_30 = 8'h30;

  localparam logic [7:0] POS_HIGH_MIN = 8'd5;
  localparam logic [7:0] POS_BACKOFF  = 8'd2;

  typedef struct packed {
    logic [7:0] step_count;
    logic [7:0] new_position;
    logic [7:0] old_position;
  } in_data_t;

  typedef struct packed {
    logic [1:0] pad;
    logic [7:0] copy_value;
    logic [7:0] wave_byte;
    logic [2:0] wave_mode;
    logic [2:0] sync_state;
  } out_data_t;

endpackage

### design/rotor_position_sync_fsm_top.sv
`timescale 1ns / 1ps
// data path: an accepted input is held in the input register, then its result in the result register
// throughput: one item per cycle while the result is not stalled; the sync state register feeds its own next state
// in_tready drops only while an item waits in the input register and the result is stalled
// reset: synchronous active-low rst_n clears both valid flags and the sync state to 0
module rotor_position_sync_fsm_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // old_position[7:0], new_position[15:8], step_count[23:16]
  input  logic        in_tuser,   // resync
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // sync_state[2:0], wave_mode[5:3], wave_byte[13:6],
                                  // copy_value[21:14], zero fill[23:22]
  output logic        out_tuser   // copy_valid
);
  import rpsf_pkg::*;

  logic        in_valid_r;
  in_data_t    in_data_r;
  logic        in_resync_r;
  sync_state_t state_r;
  sync_state_t state_nxt;
  logic        out_valid_r;
  out_data_t   out_data_r;
  out_data_t   out_data_nxt;
  logic        out_copy_r;
  logic        out_copy_nxt;

  logic        adv;
  logic        odd;
  logic        eq_flag;
  sync_state_t seed_state;
  logic        seed_flag;
  logic [7:0]  old_p;
  logic [7:0]  new_p;
  logic [7:0]  back_pos;
  logic        back_ge;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || adv;

  assign old_p    = in_data_r.old_position;
  assign new_p    = in_data_r.new_position;
  assign odd      = in_data_r.step_count[0];
  assign back_pos = old_p - POS_BACKOFF;
  assign back_ge  = $signed({back_pos[7], back_pos}) >= $signed({1'b0, new_p});

  // stage a: reseed
  always_comb begin
    seed_state = state_r;
    seed_flag  = 1'b0;
    if (in_resync_r) begin
      if (old_p > new_p) begin
        seed_state = SYNC_FALL;
      end else if (old_p == new_p) begin
        seed_state = SYNC_EQUAL;
        seed_flag  = 1'b1;
      end else begin
        seed_state = SYNC_RISE;
      end
    end
  end

  // stage b: next state
  always_comb begin
    state_nxt = seed_state;
    eq_flag   = seed_flag;
    case (seed_state)
      SYNC_FALL: begin
        if (old_p == new_p && !odd) begin
          state_nxt = SYNC_EQUAL;
          eq_flag   = 1'b1;
        end else if (old_p < new_p && !odd) begin
          state_nxt = SYNC_HOLD;
        end
      end
      SYNC_RISE: begin
        if (!odd || new_p == 8'd0) begin
          if (old_p > new_p) begin
            state_nxt = SYNC_HOLD;
          end else if (old_p == new_p) begin
            if (new_p >= POS_HIGH_MIN) begin
              state_nxt = SYNC_HIGH;
            end else begin
              state_nxt = SYNC_EQUAL;
              eq_flag   = 1'b1;
            end
          end
        end
      end
      SYNC_EQUAL: begin
        if (old_p > new_p) begin
          state_nxt = SYNC_FALL;
        end else if (old_p < new_p) begin
          state_nxt = SYNC_RISE;
        end
      end
      SYNC_HOLD: begin
        if (old_p > new_p) begin
          state_nxt = SYNC_FALL;
        end else if (old_p < new_p) begin
          state_nxt = SYNC_RISE;
        end else begin
          state_nxt = SYNC_EQUAL;
          eq_flag   = 1'b1;
        end
      end
      SYNC_HIGH: begin
        if (!odd) begin
          if (old_p < POS_HIGH_MIN) begin
            state_nxt = SYNC_EQUAL;
            eq_flag   = 1'b1;
          end else if (back_ge) begin
            state_nxt = SYNC_HOLD;
          end
        end
      end
      default: begin
        state_nxt = seed_state;
      end
    endcase
  end

  // stage c: outputs
  always_comb begin
    out_data_nxt            = '0;
    out_copy_nxt            = 1'b0;
    out_data_nxt.sync_state = state_nxt;
    case (state_nxt)
      SYNC_FALL: begin
        out_data_nxt.wave_mode = MODE_FALL;
        out_data_nxt.wave_byte = WAVE_BYTE_10;
      end
      SYNC_RISE, SYNC_HIGH: begin
        if (new_p >= POS_HIGH_MIN) begin
          out_data_nxt.wave_mode = MODE_HIGH;
          out_data_nxt.wave_byte = WAVE_BYTE_10;
        end else begin
          out_data_nxt.wave_mode = MODE_LOW;
          out_data_nxt.wave_byte = odd ? WAVE_BYTE_08 : WAVE_BYTE_30;
        end
      end
      SYNC_EQUAL: begin
        out_data_nxt.wave_byte = WAVE_BYTE_04;
        if (eq_flag && new_p == 8'd0) begin
          out_copy_nxt            = 1'b1;
          out_data_nxt.copy_value = in_data_r.step_count;
        end else begin
          out_data_nxt.wave_mode = MODE_EQUAL;
        end
      end
      SYNC_HOLD: begin
        out_data_nxt.wave_mode = MODE_NONE;
        out_data_nxt.wave_byte = WAVE_BYTE_30;
      end
      default: begin
        out_data_nxt.wave_mode = MODE_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= SYNC_FALL;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= in_valid_r;
      end
      if (in_valid_r && adv) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r   <= in_tdata;
      in_resync_r <= in_tuser;
    end
    if (in_valid_r && adv) begin
      out_data_r <= out_data_nxt;
      out_copy_r <= out_copy_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_copy_r;

  a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r <= SYNC_HIGH)
    else $error("sync state left the legal range");

  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.sync_state == state_r)
    else $error("result state differs from sync state register");

  a_copy_only_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_copy_r) |-> (out_data_r.sync_state == SYNC_EQUAL &&
      out_data_r.wave_mode == MODE_NONE && out_data_r.wave_byte == WAVE_BYTE_04))
    else $error("copy flagged outside equal state");

  a_copy_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_copy_r) |-> out_data_r.copy_value == 8'd0)
    else $error("copy value nonzero without copy");

  a_state_moves_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid_r && adv) |=> $stable(state_r))
    else $error("sync state changed without an item");

endmodule
